// ===== hw/rtl/wfc_pkg.sv =====
// Shared constants for the word frequency counter.
// Status codes of a result and the ASCII letter bounds. No dependencies.
`timescale 1ns / 1ps

package wfc_pkg;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_LONG = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    // ASCII letter bounds
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

endpackage

// ===== hw/rtl/wfc_in_if.sv =====
// Input channel of the word frequency counter: one text byte per transfer.
// Valid/ready handshake. No dependencies.
`timescale 1ns / 1ps

interface wfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_mark;

    modport source (output valid, output text_byte, output end_mark, input ready);
    modport sink   (input valid, input text_byte, input end_mark, output ready);
endinterface

// ===== hw/rtl/wfc_out_if.sv =====
// Result channel of the word frequency counter: one finished word per transfer.
// Valid/ready handshake. No dependencies.
`timescale 1ns / 1ps

interface wfc_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  entry_index;
    logic [15:0] word_count;
    logic        is_new;
    logic [1:0]  status;

    modport source (output valid, output entry_index, output word_count,
                    output is_new, output status, input ready);
    modport sink   (input valid, input entry_index, input word_count,
                    input is_new, input status, output ready);
endinterface

// ===== hw/rtl/wfc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module wfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/word_frequency_counter.sv =====
// Word frequency counter top level; uses wfc_pkg, wfc_in_if, wfc_out_if, wfc_ram.
// Letters build a pending word; each finished word is looked up and counted.
`timescale 1ns / 1ps

// Takes one text byte per transfer. A letter is folded to lower case and
// stored in the pending word RAM. A non-letter byte or an end mark ends a
// non-empty pending word and starts a linear walk of the word table, held in
// RAM: each stored entry has its length read and checked (S_MREQ, S_MCHK),
// and when the length matches its characters are compared one per key RAM
// read (S_CREQ, S_CCHK). A miss copies the word into the table one character
// at a time (S_IREQ, S_IWR), or reports ST_FULL if the table is full; S_EMIT
// then hands the result to the output register once that register is free.
// An over-long word goes from idle straight to S_EMIT with ST_LONG. Input is
// taken only while no lookup runs; a finished result waits in the output
// register without holding up the next bytes. The RAMs are not cleared: only
// entries already written are ever read.
module word_frequency_counter
    import wfc_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_LEN     = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wfc_in_if.sink        i_in,
    wfc_out_if.source     o_out
);

    localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W   = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int CH_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int KEY_D    = TABLE_DEPTH * MAX_LEN;
    localparam int KEY_AW   = (KEY_D > 1) ? $clog2(KEY_D) : 1;
    localparam int META_W   = LEN_W + COUNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MREQ, S_MCHK, S_CREQ, S_CCHK, S_IREQ, S_IWR, S_EMIT
    } t_state;

    t_state                r_state;
    logic [LEN_W-1:0]      r_len;
    logic                  r_ovf;
    logic [USED_W-1:0]     r_used;
    logic [IDX_W-1:0]      r_entry;
    logic [KEY_AW-1:0]     r_base;
    logic [CH_W-1:0]       r_char;
    logic [IDX_W-1:0]      r_res_idx;
    logic [COUNT_BITS-1:0] r_res_cnt;
    logic                  r_res_new;
    t_status               r_res_st;
    logic                  r_o_valid;
    logic [IDX_W-1:0]      r_o_idx;
    logic [COUNT_BITS-1:0] r_o_cnt;
    logic                  r_o_new;
    t_status               r_o_st;

    logic                  in_xfer;
    logic                  is_upper;
    logic                  is_letter;
    logic [7:0]            folded;
    logic                  pend_we;
    logic [7:0]            pend_rdata;
    logic                  key_we;
    logic [KEY_AW-1:0]     key_addr;
    logic [7:0]            key_rdata;
    logic                  meta_we;
    logic [META_W-1:0]     meta_wdata;
    logic [META_W-1:0]     meta_rdata;
    logic [LEN_W-1:0]      m_len;
    logic [COUNT_BITS-1:0] m_cnt;
    logic [COUNT_BITS-1:0] cnt_next;
    logic                  last_entry;
    logic                  last_char;
    logic                  out_free;

    // character classification
    always_comb begin
        is_upper  = i_in.text_byte inside {[CH_UPPER_A:CH_UPPER_Z]};
        is_letter = !i_in.end_mark &&
                    (is_upper || (i_in.text_byte inside {[CH_LOWER_A:CH_LOWER_Z]}));
        folded    = i_in.text_byte | CASE_BIT;
    end

    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free   = !r_o_valid || o_out.ready;

    // lookup helpers
    assign m_len      = meta_rdata[COUNT_BITS +: LEN_W];
    assign m_cnt      = meta_rdata[COUNT_BITS-1:0];
    assign cnt_next   = (&m_cnt) ? m_cnt : m_cnt + COUNT_BITS'(1);
    assign last_entry = (USED_W'(r_entry) + USED_W'(1)) == r_used;
    assign last_char  = (LEN_W'(r_char) + LEN_W'(1)) == r_len;
    assign key_addr   = r_base + KEY_AW'(r_char);

    // RAM write controls
    always_comb begin
        pend_we    = (r_state == S_IDLE) && in_xfer && is_letter &&
                     (r_len < LEN_W'(MAX_LEN));
        key_we     = (r_state == S_IWR);
        meta_we    = 1'b0;
        meta_wdata = {r_len, COUNT_BITS'(1)};
        case (r_state)
            S_CCHK: begin
                if (key_rdata == pend_rdata && last_char) begin
                    meta_we    = 1'b1;
                    meta_wdata = {m_len, cnt_next};
                end
            end
            S_IWR: begin
                meta_we = last_char;
            end
            default: begin
                meta_we = 1'b0;
            end
        endcase
    end

    // pending word letters
    wfc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (CH_W'(r_len)),
        .i_wdata (folded),
        .i_raddr (r_char),
        .o_rdata (pend_rdata)
    );

    // stored word letters, MAX_LEN per entry
    wfc_ram #(.WIDTH(8), .DEPTH(KEY_D)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_addr),
        .i_wdata (pend_rdata),
        .i_raddr (key_addr),
        .o_rdata (key_rdata)
    );

    // stored word length and count per entry
    wfc_ram #(.WIDTH(META_W), .DEPTH(TABLE_DEPTH)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_entry),
        .i_wdata (meta_wdata),
        .i_raddr (r_entry),
        .o_rdata (meta_rdata)
    );

    // sequencer, pending word state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_used    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // the emit state reloads the register itself
            if (o_out.valid && o_out.ready && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_entry <= '0;
                    r_base  <= '0;
                    r_char  <= '0;
                    if (in_xfer) begin
                        if (is_letter) begin
                            if (r_len < LEN_W'(MAX_LEN)) begin
                                r_len <= r_len + LEN_W'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end else if (r_ovf) begin
                            r_res_idx <= '0;
                            r_res_cnt <= '0;
                            r_res_new <= 1'b0;
                            r_res_st  <= ST_LONG;
                            r_state   <= S_EMIT;
                        end else if (r_len != '0) begin
                            r_state <= (r_used == '0) ? S_IREQ : S_MREQ;
                        end
                    end
                end
                S_MREQ: begin
                    r_state <= S_MCHK;
                end
                S_MCHK, S_CCHK: begin
                    if (r_state == S_MCHK && m_len == r_len) begin
                        r_char  <= '0;
                        r_state <= S_CREQ;
                    end else if (r_state == S_CCHK && key_rdata == pend_rdata) begin
                        if (last_char) begin
                            r_res_idx <= r_entry;
                            r_res_cnt <= cnt_next;
                            r_res_new <= 1'b0;
                            r_res_st  <= ST_OK;
                            r_state   <= S_EMIT;
                        end else begin
                            r_char  <= r_char + CH_W'(1);
                            r_state <= S_CREQ;
                        end
                    end else if (!last_entry) begin
                        r_entry <= r_entry + IDX_W'(1);
                        r_base  <= r_base + KEY_AW'(MAX_LEN);
                        r_state <= S_MREQ;
                    end else if (r_used == USED_W'(TABLE_DEPTH)) begin
                        r_res_idx <= '0;
                        r_res_cnt <= '0;
                        r_res_new <= 1'b0;
                        r_res_st  <= ST_FULL;
                        r_state   <= S_EMIT;
                    end else begin
                        r_entry <= IDX_W'(r_used);
                        r_base  <= r_base + KEY_AW'(MAX_LEN);
                        r_char  <= '0;
                        r_state <= S_IREQ;
                    end
                end
                S_CREQ: begin
                    r_state <= S_CCHK;
                end
                S_IREQ: begin
                    r_state <= S_IWR;
                end
                S_IWR: begin
                    if (last_char) begin
                        r_used    <= r_used + USED_W'(1);
                        r_res_idx <= r_entry;
                        r_res_cnt <= COUNT_BITS'(1);
                        r_res_new <= 1'b1;
                        r_res_st  <= ST_OK;
                        r_state   <= S_EMIT;
                    end else begin
                        r_char  <= r_char + CH_W'(1);
                        r_state <= S_IREQ;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_idx   <= r_res_idx;
                        r_o_cnt   <= r_res_cnt;
                        r_o_new   <= r_res_new;
                        r_o_st    <= r_res_st;
                        r_len     <= '0;
                        r_ovf     <= 1'b0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_o_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.entry_index = 6'(r_o_idx);
    assign o_out.word_count  = 16'(r_o_cnt);
    assign o_out.is_new      = r_o_new;
    assign o_out.status      = r_o_st;

    // table fill never passes its depth
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // pending length never passes the word limit
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_LEN))
        else $error("pending length beyond word limit");

    // finishing an insert adds exactly one entry
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IWR && last_char) |=> (r_used == $past(r_used) + USED_W'(1)))
        else $error("insert did not add one entry");

    // a result is loaded only when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !out_free) |=> (r_state == S_EMIT && $stable(r_o_idx)))
        else $error("result overwrote a pending transfer");

endmodule
